### sv/sceat_pkg.sv
// ----------------------------------------------------------------------------
// sceat_pkg: shared types and constants of the encoder angle tracker
// field widths, opcode and status codes, register indexes and the control
// word that travels from the front stage through the queue to the back end
// ----------------------------------------------------------------------------
package sceat_pkg;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int TICK_IN_W  = 32;
  localparam int CMD_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int ANGLE_W    = 48;
  localparam int WRAP_W     = 25;
  localparam int MAG_W      = ANGLE_W + 1;
  localparam int TPR_W      = 16;
  localparam int DB_W       = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((TICK_IN_W + CMD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ANGLE_W + WRAP_W + 7) / 8) * 8;

  // one full turn in whole degrees
  localparam int TURN_DEG = 360;
  localparam int DEG_W    = 9;

  localparam int QUEUE_DEPTH = 2;

  // parameter defaults
  localparam int TICK_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TPR_FWD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TPR_REV  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_LATCHED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOMOTION = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEADBAND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ZEROTPR  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ROLLBACK = 3'd5;
  localparam logic [STATUS_W-1:0] ST_RESET    = 3'd6;
  localparam logic [STATUS_W-1:0] ST_ZEROED   = 3'd7;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_RESET  = 2'd1,
    OP_ZERO   = 2'd2,
    OP_IDLE   = 2'd3
  } op_e;

  // classified item
  typedef struct packed {
    op_e              op;
    logic             db_hit;    // command inside deadband
    logic             sub;       // motion subtracts from the angle
    logic             tpr_zero;  // selected ticks per turn is zero
    logic [TPR_W-1:0] tpr;       // selected ticks per turn
  } ctl_t;

endpackage

### sv/sceat_front.sv
// ----------------------------------------------------------------------------
// sceat_front: input stage of the encoder angle tracker
// holds the configuration registers, classifies each input transaction
// (deadband, direction, ticks per turn) and registers it for the queue
// ----------------------------------------------------------------------------
module sceat_front
  import sceat_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OP_W-1:0]        in_op_i,
  input  logic [TICK_IN_W-1:0]   in_ticks_i,
  input  logic signed [CMD_W-1:0] in_cmd_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output ctl_t                   out_ctl_o,
  output logic [TICK_BITS-1:0]   out_ticks_o
);

  logic [DB_W-1:0]  deadband_q;
  logic             negate_q;
  logic [TPR_W-1:0] tpr_fwd_q;
  logic [TPR_W-1:0] tpr_rev_q;

  logic                 vld_q;
  ctl_t                 ctl_q, ctl_d;
  logic [TICK_BITS-1:0] ticks_q;

  logic [63:0]      ticks_ext;
  logic [CMD_W-1:0] cmd_mag;
  logic             cmd_neg;
  logic             take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q <= '0;
      negate_q   <= 1'b0;
      tpr_fwd_q  <= '0;
      tpr_rev_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEADBAND: deadband_q <= cfg_data_i[DB_W-1:0];
        CFG_NEGATE:   negate_q   <= cfg_data_i[0];
        CFG_TPR_FWD:  tpr_fwd_q  <= cfg_data_i[TPR_W-1:0];
        CFG_TPR_REV:  tpr_rev_q  <= cfg_data_i[TPR_W-1:0];
        default: ;
      endcase
    end
  end

  // count taken modulo the tick width
  assign ticks_ext = 64'(in_ticks_i);

  // full negative command gives magnitude 2^15, above any deadband
  assign cmd_neg = in_cmd_i[CMD_W-1];
  assign cmd_mag = cmd_neg ? (~in_cmd_i + 1'b1) : in_cmd_i;

  always_comb begin
    ctl_d.op       = op_e'(in_op_i);
    ctl_d.db_hit   = cmd_mag <= CMD_W'(deadband_q);
    ctl_d.tpr      = cmd_neg ? tpr_rev_q : tpr_fwd_q;
    ctl_d.tpr_zero = (cmd_neg ? tpr_rev_q : tpr_fwd_q) == '0;
    ctl_d.sub      = cmd_neg ^ negate_q;
  end

  assign in_ready_o = !vld_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ctl_q   <= ctl_d;
      ticks_q <= ticks_ext[TICK_BITS-1:0];
    end
  end

  assign out_valid_o = vld_q;
  assign out_ctl_o   = ctl_q;
  assign out_ticks_o = ticks_q;

endmodule

### sv/sceat_fifo.sv
// ----------------------------------------------------------------------------
// sceat_fifo: short queue between classifier and back end
// lets the input side keep taking transactions while the back end computes
// ----------------------------------------------------------------------------
module sceat_fifo
  import sceat_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  ctl_t                 push_ctl_i,
  input  logic [TICK_BITS-1:0] push_ticks_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output ctl_t                 pop_ctl_o,
  output logic [TICK_BITS-1:0] pop_ticks_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  ctl_t                 ctl_mem [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] ticks_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push && !pop)      cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ctl_mem[wr_ptr_q]   <= push_ctl_i;
      ticks_mem[wr_ptr_q] <= push_ticks_i;
    end
  end

  assign pop_ctl_o   = ctl_mem[rd_ptr_q];
  assign pop_ticks_o = ticks_mem[rd_ptr_q];

endmodule

### sv/sceat_div.sv
// ----------------------------------------------------------------------------
// sceat_div: radix-4 serial divider for the angle increment
// computes min(floor(dt * 360 * 2^FRAC_BITS / tpr), 2^48), two quotient bits
// per cycle
// ----------------------------------------------------------------------------
module sceat_div
  import sceat_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [TICK_BITS-1:0] dt_i,
  input  logic [TPR_W-1:0]     tpr_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [MAG_W-1:0]     mag_o
);

  localparam int PROD_W = TICK_BITS + DEG_W;
  localparam int NUM_W  = PROD_W + FRAC_BITS;
  localparam int NUM_W2 = NUM_W + (NUM_W % 2);
  localparam int STEPS  = NUM_W2 / 2;
  localparam int CNT_W  = $clog2(STEPS + 1);
  localparam int R4_W   = TPR_W + 2;
  localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {ANGLE_W{1'b0}}};

  logic [NUM_W2-1:0] num_q;
  logic [TPR_W-1:0]  rem_q;
  logic [R4_W-1:0]   t1_q, t3_q;
  logic [MAG_W-1:0]  quo_q;
  logic              ovf_q;
  logic              busy_q, done_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [PROD_W-1:0] prod;
  logic [R4_W-1:0]   t2, r4, r4n;
  logic [1:0]        dig;

  assign prod = PROD_W'(dt_i) * PROD_W'(TURN_DEG);
  assign t2   = {t1_q[R4_W-2:0], 1'b0};
  assign r4   = {rem_q, num_q[NUM_W2-1 -: 2]};

  always_comb begin
    if (r4 >= t3_q) begin
      r4n = r4 - t3_q;
      dig = 2'd3;
    end else if (r4 >= t2) begin
      r4n = r4 - t2;
      dig = 2'd2;
    end else if (r4 >= t1_q) begin
      r4n = r4 - t1_q;
      dig = 2'd1;
    end else begin
      r4n = r4;
      dig = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NUM_W2'({prod, {FRAC_BITS{1'b0}}});
      rem_q <= '0;
      t1_q  <= R4_W'(tpr_i);
      t3_q  <= R4_W'({tpr_i, 1'b0}) + R4_W'(tpr_i);
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[NUM_W2-3:0], 2'b00};
      rem_q <= r4n[TPR_W-1:0];
      quo_q <= {quo_q[MAG_W-3:0], dig};
      // any bit pushed out of the top means the quotient is past the cap
      ovf_q <= ovf_q | (|quo_q[MAG_W-1 -: 2]);
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign mag_o  = (ovf_q || quo_q > MAG_CAP) ? MAG_CAP : quo_q;

endmodule

### sv/sceat_back.sv
// ----------------------------------------------------------------------------
// sceat_back: tracker state and result sequencer
// applies one queued item to the tracker state, runs the increment divide,
// forms the relative angle, wraps it to one turn and holds the result
// ----------------------------------------------------------------------------
module sceat_back
  import sceat_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  ctl_t                      q_ctl_i,
  input  logic [TICK_BITS-1:0]      q_ticks_i,
  output logic                      div_start_o,
  output logic [TICK_BITS-1:0]      div_dt_o,
  output logic [TPR_W-1:0]          div_tpr_o,
  input  logic                      div_done_i,
  input  logic [MAG_W-1:0]          div_mag_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [STATUS_W-1:0]       m_status_o,
  output logic signed [ANGLE_W-1:0] m_rel_o,
  output logic [WRAP_W-1:0]         m_wrap_o
);

  // integer degrees part of the relative angle, reduced mod 360 in three
  // steps: 360 = 8 * 45 and 2^12 is 1 mod 45, so the twelve-bit chunks of
  // (deg >> 3) are summed, then a reciprocal multiply gives the rest mod 45
  localparam int INT_W     = ANGLE_W - FRAC_BITS;
  localparam int MOD_C     = int'((64'd1 << INT_W) % TURN_DEG);
  localparam int LOW_W     = 3;
  localparam int TURN_ODD  = TURN_DEG >> LOW_W;
  localparam int CH_W      = 12;
  localparam int HI_W      = INT_W - LOW_W;
  localparam int NCH       = (HI_W + CH_W - 1) / CH_W;
  localparam int FOLD_W    = CH_W + 2;
  localparam int RCP_SH    = 20;
  localparam int RCP_M     = ((1 << RCP_SH) + TURN_ODD - 1) / TURN_ODD;
  localparam int PRD_W     = FOLD_W + 15;
  localparam int Q45_W     = 9;
  localparam int R45_W     = 6;
  localparam int WR_W      = DEG_W + FRAC_BITS;
  localparam int WRX_W     = WR_W + WRAP_W;
  localparam int SUM_W     = ANGLE_W + 2;

  localparam logic signed [SUM_W-1:0]   SUM_MAX = (SUM_W'(1) <<< (ANGLE_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0]   SUM_MIN = -(SUM_W'(1) <<< (ANGLE_W - 1));
  localparam logic signed [ANGLE_W:0]   DIF_MAX = ((ANGLE_W + 1)'(1) <<< (ANGLE_W - 1)) - 1;
  localparam logic signed [ANGLE_W:0]   DIF_MIN = -((ANGLE_W + 1)'(1) <<< (ANGLE_W - 1));

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_REL   = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_RECIP = 3'd5;
  localparam logic [2:0] S_MOD   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]                state_q, state_d;
  logic                      have_q, have_d;
  logic [TICK_BITS-1:0]      prev_q, prev_d;
  logic signed [ANGLE_W-1:0] acc_q, acc_d;
  logic signed [ANGLE_W-1:0] zero_q, zero_d;
  logic [TICK_BITS-1:0]      dt_q, dt_d;
  logic [TPR_W-1:0]          tpr_q, tpr_d;
  logic                      sub_q, sub_d;
  logic [STATUS_W-1:0]       status_q, status_d;
  logic signed [ANGLE_W-1:0] rel_q, rel_d;
  logic [INT_W-1:0]          ideg_q, ideg_d;
  logic [FOLD_W-1:0]         fold_q, fold_d;
  logic [Q45_W-1:0]          q45_q, q45_d;
  logic [DEG_W-1:0]          r_q, r_d;
  logic                      ov_q, ov_d;
  logic [STATUS_W-1:0]       o_status_q, o_status_d;
  logic signed [ANGLE_W-1:0] o_rel_q, o_rel_d;
  logic [WRAP_W-1:0]         o_wrap_q, o_wrap_d;

  logic [TICK_BITS-1:0]      dt_c;
  logic                      back_c;
  logic signed [SUM_W-1:0]   acc_x, mag_x, sum_c;
  logic signed [ANGLE_W-1:0] acc_sat;
  logic signed [ANGLE_W:0]   dif_c;
  logic signed [ANGLE_W-1:0] rel_c;
  logic [NCH*CH_W-1:0]       hi_pad;
  logic [FOLD_W-1:0]         fold_c;
  logic [PRD_W-1:0]          prd_c;
  logic [FOLD_W-1:0]         r45_c;
  logic [DEG_W:0]            fix_c;
  logic [WR_W-1:0]           wr_c;
  logic [WRX_W-1:0]          wrx_c;
  logic                      out_free;

  assign dt_c   = q_ticks_i - prev_q;
  assign back_c = q_ticks_i < prev_q;

  // accumulate with saturation to the angle range
  assign acc_x = SUM_W'(acc_q);
  assign mag_x = signed'(SUM_W'(div_mag_i));
  assign sum_c = sub_q ? (acc_x - mag_x) : (acc_x + mag_x);

  always_comb begin
    if (sum_c > SUM_MAX)      acc_sat = SUM_MAX[ANGLE_W-1:0];
    else if (sum_c < SUM_MIN) acc_sat = SUM_MIN[ANGLE_W-1:0];
    else                      acc_sat = sum_c[ANGLE_W-1:0];
  end

  assign dif_c = (ANGLE_W + 1)'(acc_q) - (ANGLE_W + 1)'(zero_q);

  always_comb begin
    if (dif_c > DIF_MAX)      rel_c = DIF_MAX[ANGLE_W-1:0];
    else if (dif_c < DIF_MIN) rel_c = DIF_MIN[ANGLE_W-1:0];
    else                      rel_c = dif_c[ANGLE_W-1:0];
  end

  // chunk sum keeps the value mod 45, at most four chunks of 4095
  assign hi_pad = (NCH * CH_W)'(ideg_q[INT_W-1:LOW_W]);

  always_comb begin
    fold_c = '0;
    for (int i = 0; i < NCH; i++) begin
      fold_c = fold_c + FOLD_W'(hi_pad[i*CH_W +: CH_W]);
    end
  end

  // floor(fold / 45) by reciprocal, exact over the whole fold range
  assign prd_c = PRD_W'(fold_q) * PRD_W'(RCP_M);
  assign r45_c = fold_q - FOLD_W'(q45_q) * FOLD_W'(TURN_ODD);

  // a negative angle was reduced as its two's complement pattern, so take
  // 2^INT_W mod 360 back out
  always_comb begin
    if (!rel_q[ANGLE_W-1])                  fix_c = (DEG_W + 1)'(r_q);
    else if (r_q >= DEG_W'(MOD_C))          fix_c = (DEG_W + 1)'(r_q) - (DEG_W + 1)'(MOD_C);
    else fix_c = (DEG_W + 1)'(r_q) + (DEG_W + 1)'(TURN_DEG - MOD_C);
  end

  assign wr_c  = {fix_c[DEG_W-1:0], rel_q[FRAC_BITS-1:0]};
  assign wrx_c = WRX_W'(wr_c);

  assign out_free = !ov_q || m_ready_i;

  always_comb begin
    state_d    = state_q;
    have_d     = have_q;
    prev_d     = prev_q;
    acc_d      = acc_q;
    zero_d     = zero_q;
    dt_d       = dt_q;
    tpr_d      = tpr_q;
    sub_d      = sub_q;
    status_d   = status_q;
    rel_d      = rel_q;
    ideg_d     = ideg_q;
    fold_d     = fold_q;
    q45_d      = q45_q;
    r_d        = r_q;
    ov_d       = ov_q && !m_ready_i;
    o_status_d = o_status_q;
    o_rel_d    = o_rel_q;
    o_wrap_d   = o_wrap_q;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          state_d = S_REL;
          case (q_ctl_i.op)
            OP_SAMPLE: begin
              prev_d = q_ticks_i;
              if (!have_q) begin
                have_d   = 1'b1;
                status_d = ST_LATCHED;
              end else if (back_c) begin
                acc_d    = '0;
                zero_d   = '0;
                status_d = ST_ROLLBACK;
              end else if (dt_c == '0) begin
                status_d = ST_NOMOTION;
              end else if (q_ctl_i.db_hit) begin
                status_d = ST_DEADBAND;
              end else if (q_ctl_i.tpr_zero) begin
                status_d = ST_ZEROTPR;
              end else begin
                status_d = ST_COUNTED;
                dt_d     = dt_c;
                tpr_d    = q_ctl_i.tpr;
                sub_d    = q_ctl_i.sub;
                state_d  = S_START;
              end
            end
            OP_RESET: begin
              have_d   = 1'b0;
              prev_d   = '0;
              acc_d    = '0;
              zero_d   = '0;
              status_d = ST_RESET;
            end
            OP_ZERO: begin
              zero_d   = acc_q;
              status_d = ST_ZEROED;
            end
            default: begin
              status_d = ST_NOMOTION;
            end
          endcase
        end
      end
      S_START: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done_i) begin
          acc_d   = acc_sat;
          state_d = S_REL;
        end
      end
      S_REL: begin
        rel_d   = rel_c;
        ideg_d  = rel_c[ANGLE_W-1:FRAC_BITS];
        state_d = S_FOLD;
      end
      S_FOLD: begin
        fold_d  = fold_c;
        state_d = S_RECIP;
      end
      S_RECIP: begin
        q45_d   = prd_c[RCP_SH +: Q45_W];
        state_d = S_MOD;
      end
      S_MOD: begin
        r_d     = {r45_c[R45_W-1:0], ideg_q[LOW_W-1:0]};
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_rel_d    = rel_q;
          o_wrap_d   = wrx_c[WRAP_W-1:0];
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      have_q  <= 1'b0;
      prev_q  <= '0;
      acc_q   <= '0;
      zero_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      have_q  <= have_d;
      prev_q  <= prev_d;
      acc_q   <= acc_d;
      zero_q  <= zero_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q       <= dt_d;
    tpr_q      <= tpr_d;
    sub_q      <= sub_d;
    status_q   <= status_d;
    rel_q      <= rel_d;
    ideg_q     <= ideg_d;
    fold_q     <= fold_d;
    q45_q      <= q45_d;
    r_q        <= r_d;
    o_status_q <= o_status_d;
    o_rel_q    <= o_rel_d;
    o_wrap_q   <= o_wrap_d;
  end

  assign q_ready_o   = state_q == S_IDLE;
  assign div_start_o = state_q == S_START;
  assign div_dt_o    = dt_q;
  assign div_tpr_o   = tpr_q;
  assign m_valid_o   = ov_q;
  assign m_status_o  = o_status_q;
  assign m_rel_o     = o_rel_q;
  assign m_wrap_o    = o_wrap_q;

endmodule

### sv/single_channel_encoder_angle_tracker.sv
// ----------------------------------------------------------------------------
// single_channel_encoder_angle_tracker: turret angle from a direction-less
// encoder count
// Each input transaction carries an opcode, an absolute tick count and a
// signed motor command; each one gives exactly one result transaction with a
// status code, the angle relative to the zero point and that angle wrapped to
// one turn, both in degrees with FRAC_BITS fraction bits. The motor command's
// sign picks the direction and the ticks per turn. A classify stage and a
// two-entry queue take new transactions while the back end works, and the
// result sits in an output register so input keeps flowing while the output
// is stalled. The back end handles one item at a time: a counted sample first
// runs the radix-4 serial divider for the increment; the wrapped angle comes
// from the mod-360 unit (chunk fold, reciprocal multiply, remainder), which
// every item passes through. A stalled result output holds the back end in
// its last step until the result register drains.
// Configuration writes are meant for when the block is idle.
// ----------------------------------------------------------------------------
module single_channel_encoder_angle_tracker
  import sceat_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF,  // tick counter width, 16..64
  parameter int FRAC_BITS = FRAC_BITS_DEF   // angle fraction bits, 8..16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // tick_count[31:0], motor_cmd[47:32]
  input  logic [OP_W-1:0]       s_axis_tuser,   // opcode[1:0]

  // result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // angle_rel[47:0], angle_wrapped[72:48], zero pad
  output logic [STATUS_W-1:0]   m_axis_tuser    // status[2:0]
);

  // front to queue
  logic                 fr_valid, fr_ready;
  ctl_t                 fr_ctl;
  logic [TICK_BITS-1:0] fr_ticks;

  // queue to back end
  logic                 bq_valid, bq_ready;
  ctl_t                 bq_ctl;
  logic [TICK_BITS-1:0] bq_ticks;

  // divider handshake
  logic                 div_start, div_busy, div_done;
  logic [TICK_BITS-1:0] div_dt;
  logic [TPR_W-1:0]     div_tpr;
  logic [MAG_W-1:0]     div_mag;

  logic signed [ANGLE_W-1:0] angle_rel;
  logic [WRAP_W-1:0]         angle_wrapped;

  // config registers and classification of each incoming transaction
  sceat_front #(
    .TICK_BITS (TICK_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_op_i     (s_axis_tuser),
    .in_ticks_i  (s_axis_tdata[TICK_IN_W-1:0]),
    .in_cmd_i    (signed'(s_axis_tdata[TICK_IN_W +: CMD_W])),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_ctl_o   (fr_ctl),
    .out_ticks_o (fr_ticks)
  );

  // decouples the classifier from the sequencer
  sceat_fifo #(
    .TICK_BITS (TICK_BITS)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_ctl_i   (fr_ctl),
    .push_ticks_i (fr_ticks),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_ctl_o    (bq_ctl),
    .pop_ticks_o  (bq_ticks)
  );

  // serial divide of the scaled tick delta by ticks per turn
  sceat_div #(
    .TICK_BITS (TICK_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dt_i    (div_dt),
    .tpr_i   (div_tpr),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .mag_o   (div_mag)
  );

  // tracker state, relative angle, wrap and the result register
  sceat_back #(
    .TICK_BITS (TICK_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_ctl_i     (bq_ctl),
    .q_ticks_i   (bq_ticks),
    .div_start_o (div_start),
    .div_dt_o    (div_dt),
    .div_tpr_o   (div_tpr),
    .div_done_i  (div_done),
    .div_mag_i   (div_mag),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_status_o  (m_axis_tuser),
    .m_rel_o     (angle_rel),
    .m_wrap_o    (angle_wrapped)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = OUT_DATA_W'({angle_wrapped, angle_rel});

`ifndef SYNTHESIS
  // the divider is never restarted while a divide is running
  assert property (@(posedge clk_i) disable iff (!rst_ni) div_start |-> !div_busy)
    else $error("divider started while busy");

  // a divide that ends always hands its result over
  assert property (@(posedge clk_i) disable iff (!rst_ni) $fell(div_busy) |-> div_done)
    else $error("divider finished without done");

  // reset and set-zero both leave the relative angle at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_RESET || m_axis_tuser == ST_ZEROED)
    |-> m_axis_tdata[ANGLE_W+WRAP_W-1:0] == '0)
    else $error("nonzero angle after reset or zero");
`endif

endmodule
